// File: rtl/mcpf_pkg.sv
`default_nettype none

package mcpf_pkg;

  // operation codes carried on the opcode field
  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_FREE     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_CLOSE_WR = 3'd4,
    OP_CLOSE_RD = 3'd5
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EOF   = 2'd1,
    STATUS_RETRY = 2'd2,
    STATUS_ERROR = 2'd3
  } status_t;

  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] TALLY_MAX = 13'h1FFF;
  localparam int MAX_ADDRESSABLE = 8;

  // response of the channel table to one accepted operation
  typedef struct packed {
    logic               has_result;  // single result item to emit
    status_t            status;
    logic [COUNT_W-1:0] byte_count;
    logic [2:0]         granted;
    logic               wr_en;       // append data byte to the ring
    logic               rd_burst;    // stream rd_len bytes from the ring
  } chan_resp_t;

endpackage

`default_nettype wire

// File: rtl/mcpf_byte_ram.sv
`default_nettype none

module mcpf_byte_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mcpf_chan_table.sv
`default_nettype none

module mcpf_chan_table #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int MAX_READ     = 64,
  parameter int CH_N         = 8,
  parameter int CHW          = 3,
  parameter int PTRW         = 12,
  parameter int FILLW        = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire logic [2:0]        opcode,
  input  wire logic [2:0]        channel,
  input  wire logic              burst_end,
  input  wire logic [6:0]        read_length,
  output mcpf_pkg::chan_resp_t   resp,
  output logic      [CHW-1:0]    cidx,
  output logic      [PTRW-1:0]   wr_ptr,
  output logic      [PTRW-1:0]   rd_ptr,
  output logic      [6:0]        rd_len
);

  import mcpf_pkg::*;

  localparam int CW = (FILLW > 7) ? FILLW : 7;
  localparam logic [PTRW:0]    DEPTH_C = (PTRW+1)'(BUFFER_DEPTH);
  localparam logic [FILLW-1:0] FULL_C  = FILLW'(BUFFER_DEPTH);
  localparam logic [6:0]       MAXR_C  = 7'(MAX_READ);
  localparam logic [3:0]       NCH_C   = 4'(CH_N);

  // channel descriptors
  logic [PTRW-1:0]    rp        [CH_N];
  logic [FILLW-1:0]   fill      [CH_N];
  logic [CH_N-1:0]    busy, wgone, rgone;
  logic [COUNT_W-1:0] tally;

  logic [PTRW-1:0]    rp_next   [CH_N];
  logic [FILLW-1:0]   fill_next [CH_N];
  logic [CH_N-1:0]    busy_next, wgone_next, rgone_next;
  logic [COUNT_W-1:0] tally_next;

  logic               ch_ok;
  logic               found;
  logic [CHW-1:0]     aidx;
  logic [PTRW-1:0]    rp_cur;
  logic [FILLW-1:0]   fill_cur;
  logic [PTRW:0]      wsum, rsum;
  logic [6:0]         req_c;
  logic [CW-1:0]      n_ext;
  logic [COUNT_W-1:0] tally_inc;

  assign ch_ok = ({1'b0, channel} < NCH_C);
  assign cidx  = CHW'(channel);

  // lowest free channel for alloc
  always_comb begin
    found = 1'b0;
    aidx  = '0;
    for (int i = CH_N - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        aidx  = CHW'(i);
      end
    end
  end

  // ring arithmetic for the addressed channel
  always_comb begin
    rp_cur   = ch_ok ? rp[cidx] : '0;
    fill_cur = ch_ok ? fill[cidx] : '0;
    wsum     = (PTRW+1)'(rp_cur) + (PTRW+1)'(fill_cur);
    wr_ptr   = (wsum >= DEPTH_C) ? PTRW'(wsum - DEPTH_C) : PTRW'(wsum);
    if (read_length == 7'd0) begin
      req_c = 7'd1;
    end else if (read_length > MAXR_C) begin
      req_c = MAXR_C;
    end else begin
      req_c = read_length;
    end
    n_ext  = (CW'(req_c) < CW'(fill_cur)) ? CW'(req_c) : CW'(fill_cur);
    rd_len = 7'(n_ext);
    rd_ptr = rp_cur;
    rsum   = (PTRW+1)'(rp_cur) + (PTRW+1)'(n_ext);
    tally_inc = (tally < TALLY_MAX) ? tally + COUNT_W'(1) : tally;
  end

  // operation decode and descriptor next state
  always_comb begin
    rp_next    = rp;
    fill_next  = fill;
    busy_next  = busy;
    wgone_next = wgone;
    rgone_next = rgone;
    tally_next = tally;
    resp       = '0;
    resp.status = STATUS_OK;
    if (cmd_valid) begin
      case (opcode_t'(opcode))
        OP_ALLOC: begin
          resp.has_result = 1'b1;
          if (found) begin
            busy_next[aidx]  = 1'b1;
            wgone_next[aidx] = 1'b0;
            rgone_next[aidx] = 1'b0;
            rp_next[aidx]    = '0;
            fill_next[aidx]  = '0;
            resp.granted     = 3'(aidx);
          end else begin
            resp.status = STATUS_ERROR;
          end
        end
        OP_FREE: begin
          if (ch_ok) begin
            busy_next[cidx] = 1'b0;
          end
        end
        OP_WRITE: begin
          if (!ch_ok || !busy[cidx] || rgone[cidx]) begin
            tally_next      = '0;
            resp.has_result = 1'b1;
            resp.status     = STATUS_ERROR;
          end else begin
            if (fill_cur < FULL_C) begin
              resp.wr_en      = 1'b1;
              fill_next[cidx] = fill_cur + FILLW'(1);
              tally_next      = tally_inc;
            end
            if (burst_end) begin
              resp.has_result = 1'b1;
              resp.byte_count = (fill_cur < FULL_C) ? tally_inc : tally;
              tally_next      = '0;
            end
          end
        end
        OP_READ: begin
          if (!ch_ok || !busy[cidx]) begin
            resp.has_result = 1'b1;
            resp.status     = STATUS_ERROR;
          end else if (fill_cur == '0) begin
            resp.has_result = 1'b1;
            resp.status     = wgone[cidx] ? STATUS_EOF : STATUS_RETRY;
          end else begin
            resp.rd_burst   = 1'b1;
            fill_next[cidx] = fill_cur - FILLW'(n_ext);
            rp_next[cidx]   = (rsum >= DEPTH_C) ? PTRW'(rsum - DEPTH_C) : PTRW'(rsum);
          end
        end
        OP_CLOSE_WR: begin
          if (ch_ok && busy[cidx]) begin
            wgone_next[cidx] = 1'b1;
            if (rgone[cidx]) begin
              busy_next[cidx] = 1'b0;
            end
          end
        end
        OP_CLOSE_RD: begin
          if (ch_ok && busy[cidx]) begin
            rgone_next[cidx] = 1'b1;
            if (wgone[cidx]) begin
              busy_next[cidx] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // descriptor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      wgone <= '0;
      rgone <= '0;
      tally <= '0;
      for (int i = 0; i < CH_N; i++) begin
        rp[i]   <= '0;
        fill[i] <= '0;
      end
    end else begin
      busy  <= busy_next;
      wgone <= wgone_next;
      rgone <= rgone_next;
      tally <= tally_next;
      rp    <= rp_next;
      fill  <= fill_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_channel_pipe_fifo_unit.sv
`default_nettype none

// Channel    Handshake             Payload
// --------   -------------------   ---------------------------------------------
// in         in_valid / in_ready   opcode, channel, data_byte, burst_end,
//                                  read_length
// out        out_valid/ out_ready  status, read_byte, byte_count,
//                                  granted_channel, last
//
// Writes stream one byte per cycle into the byte RAM while in_ready is high. During
// a read, one byte leaves the RAM read port per cycle while out_ready stays high,
// behind the RAM's registered read.
// Reset clears the channel descriptors at once; the byte RAM is not cleared.
// A low out_ready stalls the read stream and holds off new operations while a
// result waits in the output register.

module multi_channel_pipe_fifo_unit #(
  parameter int NUM_CHANNELS = 8,
  parameter int BUFFER_DEPTH = 4096,
  parameter int MAX_READ     = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [2:0]  channel,
  input  wire logic [7:0]  data_byte,
  input  wire logic        burst_end,
  input  wire logic [6:0]  read_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       read_byte,
  output logic [12:0]      byte_count,
  output logic [2:0]       granted_channel,
  output logic             last
);

  import mcpf_pkg::*;

  localparam int CH_N   = (NUM_CHANNELS < MAX_ADDRESSABLE) ? NUM_CHANNELS : MAX_ADDRESSABLE;
  localparam int CHW    = (CH_N > 1) ? $clog2(CH_N) : 1;
  localparam int PTRW   = $clog2(BUFFER_DEPTH);
  localparam int FILLW  = $clog2(BUFFER_DEPTH + 1);
  localparam int MEM_D  = CH_N * (2 ** PTRW);
  localparam int AW     = $clog2(MEM_D);
  localparam logic [PTRW-1:0] LAST_PTR = PTRW'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } seq_state_t;

  seq_state_t      state;
  chan_resp_t      resp;
  logic [CHW-1:0]  cidx;
  logic [PTRW-1:0] wr_ptr, start_ptr;
  logic [6:0]      start_len;

  logic            accept, out_free, issue;
  logic [CHW-1:0]  rd_ch;
  logic [PTRW-1:0] rd_ptr;
  logic [6:0]      rd_left;
  logic            pending, pend_last;
  logic [7:0]      rdata;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign issue    = (state == ST_READ) && (rd_left != 7'd0) && (!pending || out_free);

  mcpf_chan_table #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_READ     (MAX_READ),
    .CH_N         (CH_N),
    .CHW          (CHW),
    .PTRW         (PTRW),
    .FILLW        (FILLW)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (accept),
    .opcode      (opcode),
    .channel     (channel),
    .burst_end   (burst_end),
    .read_length (read_length),
    .resp        (resp),
    .cidx        (cidx),
    .wr_ptr      (wr_ptr),
    .rd_ptr      (start_ptr),
    .rd_len      (start_len)
  );

  mcpf_byte_ram #(
    .DEPTH (MEM_D),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept && resp.wr_en),
    .waddr (AW'({cidx, wr_ptr})),
    .wdata (data_byte),
    .re    (issue),
    .raddr (AW'({rd_ch, rd_ptr})),
    .rdata (rdata)
  );

  // read sequencer and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_left   <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && resp.has_result) begin
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept && resp.rd_burst) begin
            state   <= ST_READ;
            rd_left <= start_len;
          end
        end
        ST_READ: begin
          if (pending && out_free) begin
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (issue) begin
            rd_left <= rd_left - 7'd1;
            pending <= 1'b1;
          end else if (pending && out_free) begin
            pending <= 1'b0;
          end
          if (rd_left == 7'd0 && !(pending && !out_free)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read address walk and result payload
  always_ff @(posedge clk) begin
    if (accept && resp.rd_burst) begin
      rd_ch  <= cidx;
      rd_ptr <= start_ptr;
    end else if (issue) begin
      rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTRW'(1);
    end
    if (issue) begin
      pend_last <= (rd_left == 7'd1);
    end
    if (state == ST_IDLE && accept && resp.has_result) begin
      status          <= resp.status;
      read_byte       <= '0;
      byte_count      <= resp.byte_count;
      granted_channel <= resp.granted;
      last            <= 1'b1;
    end else if (state == ST_READ && pending && out_free) begin
      status          <= STATUS_OK;
      read_byte       <= rdata;
      byte_count      <= '0;
      granted_channel <= '0;
      last            <= pend_last;
    end
  end

endmodule

`default_nettype wire

// File: tb/multi_channel_pipe_fifo_checker.sv
// Watches all eight channels of the pipe pool, predicts the results of every
// accepted operation and compares them with what leaves the block.
module multi_channel_pipe_fifo_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [2:0]  channel,
  input  wire logic [7:0]  data_byte,
  input  wire logic        burst_end,
  input  wire logic [6:0]  read_length,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  status,
  input  wire logic [7:0]  read_byte,
  input  wire logic [12:0] byte_count,
  input  wire logic [2:0]  granted_channel,
  input  wire logic        last,
  output int               mismatches,
  output int               pending
);

  import mcpf_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int RING_DEPTH  = 4096;
  localparam int READ_MAX    = 64;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    status_t            st;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
    logic [2:0]         chan;
    logic               last;
  } pipe_result_t;

  // shadow of the channel table and byte rings
  logic [7:0]         ring_mem [CHANNELS][RING_DEPTH];
  logic [11:0]        rd_ptr   [CHANNELS];
  logic [12:0]        fill     [CHANNELS];
  logic               busy     [CHANNELS];
  logic               wr_shut  [CHANNELS];
  logic               rd_shut  [CHANNELS];
  logic [COUNT_W-1:0] burst_tally;

  pipe_result_t due_results [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_result(input status_t st, input logic [7:0] data,
                              input logic [COUNT_W-1:0] count, input logic [2:0] chan,
                              input logic last_flag);
    pipe_result_t r;
    r.st    = st;
    r.data  = data;
    r.count = count;
    r.chan  = chan;
    r.last  = last_flag;
    due_results.push_back(r);
  endtask

  // one operation against the shadow table; queues the results it causes
  task automatic apply_pipe_op(input logic [2:0] op, input logic [2:0] ch,
                               input logic [7:0] dat, input logic eob,
                               input logic [6:0] len);
    logic        granted;
    logic [11:0] wr_slot;
    logic [12:0] take;
    logic [COUNT_W-1:0] done_count;
    granted = 1'b0;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < MAX_ADDRESSABLE; i++) begin
          if (!granted && !busy[i]) begin
            busy[i]    = 1'b1;
            rd_ptr[i]  = '0;
            fill[i]    = '0;
            wr_shut[i] = 1'b0;
            rd_shut[i] = 1'b0;
            queue_result(STATUS_OK, 8'h00, '0, 3'(i), 1'b1);
            granted = 1'b1;
          end
        end
        if (!granted) queue_result(STATUS_ERROR, 8'h00, '0, 3'd0, 1'b1);
      end
      OP_FREE: busy[ch] = 1'b0;
      OP_WRITE: begin
        if (!busy[ch] || rd_shut[ch]) begin
          burst_tally = '0;
          queue_result(STATUS_ERROR, 8'h00, '0, 3'd0, 1'b1);
        end else begin
          // full ring drops the byte without counting it
          if (fill[ch] < 13'(RING_DEPTH)) begin
            wr_slot = rd_ptr[ch] + fill[ch][11:0];
            ring_mem[ch][wr_slot] = dat;
            fill[ch] = fill[ch] + 13'd1;
            if (burst_tally < TALLY_MAX) burst_tally = burst_tally + 1'b1;
          end
          if (eob) begin
            done_count  = burst_tally;
            burst_tally = '0;
            queue_result(STATUS_OK, 8'h00, done_count, 3'd0, 1'b1);
          end
        end
      end
      OP_READ: begin
        if (!busy[ch]) begin
          queue_result(STATUS_ERROR, 8'h00, '0, 3'd0, 1'b1);
        end else if (fill[ch] == 13'd0) begin
          queue_result(wr_shut[ch] ? STATUS_EOF : STATUS_RETRY, 8'h00, '0, 3'd0, 1'b1);
        end else begin
          // zero length reads one byte, long requests are clamped
          if (len == 7'd0) take = 13'd1;
          else if (len > 7'(READ_MAX)) take = 13'(READ_MAX);
          else take = 13'(len);
          if (take > fill[ch]) take = fill[ch];
          for (int k = 0; k < int'(take); k++) begin
            queue_result(STATUS_OK, ring_mem[ch][rd_ptr[ch]], '0, 3'd0,
                         k == int'(take) - 1);
            rd_ptr[ch] = rd_ptr[ch] + 12'd1;
          end
          fill[ch] = fill[ch] - take;
        end
      end
      OP_CLOSE_WR: begin
        if (busy[ch]) begin
          wr_shut[ch] = 1'b1;
          if (rd_shut[ch]) busy[ch] = 1'b0;
        end
      end
      OP_CLOSE_RD: begin
        if (busy[ch]) begin
          rd_shut[ch] = 1'b1;
          if (wr_shut[ch]) busy[ch] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    pipe_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result st=%0d byte=%02h count=%0d chan=%0d last=%0b",
                                status, read_byte, byte_count, granted_channel, last));
    end else begin
      want = due_results.pop_front();
      if (status !== want.st || read_byte !== want.data || byte_count !== want.count ||
          granted_channel !== want.chan || last !== want.last)
        report_mismatch($sformatf(
          "got st=%0d byte=%02h count=%0d chan=%0d last=%0b, want st=%0d byte=%02h count=%0d chan=%0d last=%0b",
          status, read_byte, byte_count, granted_channel, last,
          want.st, want.data, want.count, want.chan, want.last));
    end
  endtask

  // results are checked before the same edge's operation is queued
  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rd_ptr[c]  = '0;
        fill[c]    = '0;
        busy[c]    = 1'b0;
        wr_shut[c] = 1'b0;
        rd_shut[c] = 1'b0;
      end
      burst_tally = '0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)
        apply_pipe_op(opcode, channel, data_byte, burst_end, read_length);
    end
    pending = due_results.size();
  end

endmodule

// File: tb/multi_channel_pipe_fifo_unit_test.sv
module multi_channel_pipe_fifo_unit_test;

  import mcpf_pkg::*;

  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_OPS     = 280;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // opcodes the block ignores
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [2:0]  channel = '0;
  logic [7:0]  data_byte = '0;
  logic        burst_end = 1'b0;
  logic [6:0]  read_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic [12:0] byte_count;
  logic [2:0]  granted_channel;
  logic        last;
  int          mismatches;
  int          pending;

  // stimulus-side view of which channels are open, used to aim operations
  logic [7:0]  in_use  = '0;
  logic [7:0]  wr_shut = '0;
  logic [7:0]  rd_shut = '0;
  int          burst_left = 0;
  int          ops_sent = 0;
  int          idle_cycles = 0;
  logic        hold_tog = 1'b0;

  always #1 clk = ~clk;

  multi_channel_pipe_fifo_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .channel         (channel),
    .data_byte       (data_byte),
    .burst_end       (burst_end),
    .read_length     (read_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .read_byte       (read_byte),
    .byte_count      (byte_count),
    .granted_channel (granted_channel),
    .last            (last)
  );

  multi_channel_pipe_fifo_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .channel         (channel),
    .data_byte       (data_byte),
    .burst_end       (burst_end),
    .read_length     (read_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .read_byte       (read_byte),
    .byte_count      (byte_count),
    .granted_channel (granted_channel),
    .last            (last),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  function automatic int lowest_free();
    for (int c = 0; c < MAX_ADDRESSABLE; c++) if (!in_use[c]) return c;
    return -1;
  endfunction

  function automatic int pick_busy();
    int c;
    if (in_use == '0) return int'($urandom_range(7, 0));
    do c = int'($urandom_range(7, 0)); while (!in_use[c]);
    return c;
  endfunction

  // offer one operation, hold it until the transfer, then pace the sender
  task automatic push_op(input logic [2:0] op, input logic [2:0] ch, input logic [7:0] dat,
                         input logic eob, input logic [6:0] len);
    int slot;
    in_valid    <= 1'b1;
    opcode      <= op;
    channel     <= ch;
    data_byte   <= dat;
    burst_end   <= eob;
    read_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) ops_sent++;
    case (op)
      OP_ALLOC: begin
        slot = lowest_free();
        if (slot >= 0) begin
          in_use[slot]  = 1'b1;
          wr_shut[slot] = 1'b0;
          rd_shut[slot] = 1'b0;
        end
      end
      OP_FREE: in_use[ch] = 1'b0;
      OP_CLOSE_WR: if (in_use[ch]) begin
        wr_shut[ch] = 1'b1;
        if (rd_shut[ch]) in_use[ch] = 1'b0;
      end
      OP_CLOSE_RD: if (in_use[ch]) begin
        rd_shut[ch] = 1'b1;
        if (wr_shut[ch]) in_use[ch] = 1'b0;
      end
      default: ;
    endcase
    // bursts of random length, random gaps between them
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? int'($urandom_range(80, 30))
                                               : int'($urandom_range(12, 1));
    end
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: segments of differing ready patterns, long hold on request
  initial begin
    int   seg_left;
    int   mode;
    int   tick;
    logic seen;
    seg_left = 0;
    mode     = 0;
    tick     = 0;
    seen     = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_tog != seen) begin
        seen = hold_tog;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = int'($urandom_range(3, 0));
        seg_left = int'($urandom_range(80, 10));
      end
      seg_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(1, 0));
        2: out_ready <= ($urandom_range(7, 0) != 0);
        default: out_ready <= (tick % 4 != 3);
      endcase
    end
  end

  // watchdog on cycles without an input transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int   slot_a;
    int   slot_b;
    int   target;
    int   r;
    int   n;
    int   ch_pick;
    logic held;
    logic paused;
    held   = 1'b0;
    paused = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = 4;

    // directed: errors on unopened channels, empty ring, length limits, eof
    push_op(OP_READ, 3'd2, 8'h00, 1'b0, 7'd1);
    push_op(OP_WRITE, 3'd3, 8'h11, 1'b1, 7'd0);
    push_op(OP_ALLOC, 3'd7, 8'h00, 1'b0, 7'd0);
    push_op(OP_READ, 3'd0, 8'h00, 1'b0, 7'd5);
    push_op(OP_WRITE, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_WRITE, 3'd0, 8'hFF, 1'b0, 7'd127);
    push_op(OP_WRITE, 3'd0, 8'hA5, 1'b1, 7'd0);
    push_op(OP_READ, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_READ, 3'd0, 8'hFF, 1'b1, 7'd127);
    push_op(OP_WRITE, 3'd0, 8'h5A, 1'b1, 7'd0);
    push_op(OP_CLOSE_WR, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_READ, 3'd0, 8'h00, 1'b0, 7'd64);
    push_op(OP_READ, 3'd0, 8'h00, 1'b0, 7'd1);
    push_op(OP_CLOSE_RD, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_CLOSE_WR, 3'd5, 8'h00, 1'b0, 7'd0);
    push_op(OP_ALLOC, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_CLOSE_RD, 3'd0, 8'h00, 1'b0, 7'd0);
    push_op(OP_WRITE, 3'd0, 8'h3C, 1'b1, 7'd0);
    push_op(OP_UNUSED_LO, 3'd7, 8'hFF, 1'b1, 7'd127);
    push_op(OP_UNUSED_HI, 3'd7, 8'hFF, 1'b1, 7'd127);
    push_op(OP_FREE, 3'd0, 8'h00, 1'b0, 7'd0);
    wait_drain();

    // two rings loaded back to back
    slot_a = lowest_free();
    push_op(OP_ALLOC, 3'd0, 8'h00, 1'b0, 7'd0);
    slot_b = lowest_free();
    push_op(OP_ALLOC, 3'd0, 8'h00, 1'b0, 7'd0);
    for (int k = 0; k < 40; k++)
      push_op(OP_WRITE, 3'(slot_a), 8'($urandom_range(255, 0)), k == 39, 7'd0);
    for (int k = 0; k < 8; k++)
      push_op(OP_WRITE, 3'(slot_b), 8'($urandom_range(255, 0)), k == 7, 7'd0);

    // drain the first ring under a long receiver hold, last read finds it empty
    hold_tog <= ~hold_tog;
    for (int k = 0; k < 6; k++)
      push_op(OP_READ, 3'(slot_a), 8'h00, 1'b0, 7'd8);
    push_op(OP_CLOSE_WR, 3'(slot_a), 8'h00, 1'b0, 7'd0);
    push_op(OP_CLOSE_RD, 3'(slot_a), 8'h00, 1'b0, 7'd0);
    push_op(OP_CLOSE_RD, 3'(slot_b), 8'h00, 1'b0, 7'd0);
    push_op(OP_CLOSE_WR, 3'(slot_b), 8'h00, 1'b0, 7'd0);

    // exhaust the pool, last alloc fails
    for (int k = 0; k <= MAX_ADDRESSABLE; k++)
      push_op(OP_ALLOC, 3'($urandom_range(7, 0)), 8'h00, 1'b0, 7'd0);
    wait_drain();

    // random sessions: mostly well-formed traffic on open channels, some noise
    target = ops_sent + RANDOM_OPS;
    while (ops_sent < target) begin
      if (!held && ops_sent >= target - 250) begin
        held = 1'b1;
        hold_tog <= ~hold_tog;
      end
      if (!paused && ops_sent >= target - 120) begin
        paused = 1'b1;
        wait_drain();
      end
      r = int'($urandom_range(99, 0));
      if (in_use == '0 || r < 10) begin
        push_op(OP_ALLOC, 3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)),
                1'($urandom_range(1, 0)), 7'($urandom_range(127, 0)));
      end else if (r < 50) begin
        ch_pick = pick_busy();
        if ($urandom_range(5, 0) == 0) ch_pick = int'($urandom_range(7, 0));
        n = int'($urandom_range(24, 1));
        for (int k = 0; k < n; k++)
          push_op(OP_WRITE, 3'(ch_pick), 8'($urandom_range(255, 0)),
                  (k == n - 1) || ($urandom_range(15, 0) == 0),
                  7'($urandom_range(127, 0)));
      end else if (r < 72) begin
        push_op(OP_READ, 3'(pick_busy()), 8'($urandom_range(255, 0)),
                1'($urandom_range(1, 0)),
                ($urandom_range(3, 0) != 0) ? 7'($urandom_range(64, 1))
                                            : 7'($urandom_range(127, 0)));
      end else if (r < 80) begin
        push_op(OP_CLOSE_WR, 3'(pick_busy()), 8'h00, 1'b0, 7'd0);
      end else if (r < 86) begin
        push_op(OP_CLOSE_RD, 3'(pick_busy()), 8'h00, 1'b0, 7'd0);
      end else if (r < 90) begin
        push_op(OP_FREE, 3'(pick_busy()), 8'h00, 1'b0, 7'd0);
      end else begin
        push_op(3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)),
                8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                7'($urandom_range(127, 0)));
      end
    end

    wait_drain();
    @(negedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
